>>> design/rplf_pkg.sv
// ----------------------------------------------------------------------------
// rplf_pkg: shared types and constants of the packet link framer
// Phase codes, request and result records, mode/event/kind codes.
// ----------------------------------------------------------------------------
package rplf_pkg;

  typedef enum logic [3:0] {
    PH_LEN_HI  = 4'd0,
    PH_LEN_LO  = 4'd1,
    PH_RX_DATA = 4'd2,
    PH_SYNC    = 4'd3,
    PH_TX_HI   = 4'd4,
    PH_TX_LO   = 4'd5,
    PH_TX_DATA = 4'd6,
    PH_SUF1    = 4'd7,
    PH_SUF2    = 4'd8,
    PH_WAIT    = 4'd9
  } phase_t;

  localparam logic [2:0] MODE_RX_BYTE = 3'd0;
  localparam logic [2:0] MODE_NOTICE  = 3'd1;
  localparam logic [2:0] MODE_QUEUE   = 3'd2;
  localparam logic [2:0] MODE_PULL    = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_RX_REJECT = 3'd1;
  localparam logic [2:0] EV_TX_START  = 3'd2;
  localparam logic [2:0] EV_TX_QUEUED = 3'd3;
  localparam logic [2:0] EV_TX_REFUSE = 3'd4;
  localparam logic [2:0] EV_TX_DONE   = 3'd5;
  localparam logic [2:0] EV_TIMEOUT   = 3'd6;
  localparam logic [2:0] EV_RX_RESET  = 3'd7;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_RX   = 2'd2;

  localparam logic [1:0] CFG_MAX_RX  = 2'd0;
  localparam logic [1:0] CFG_MAX_TX  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
  localparam logic [7:0] SYNC_HI_BYTE  = 8'h2D;
  localparam logic [7:0] SYNC_LO_BYTE  = 8'hD4;
  localparam logic [15:0] SYNC_HI_POS  = 16'd3;
  localparam logic [15:0] SYNC_LEN     = 16'd5;

  localparam logic [15:0] MAX_RX_RESET  = 16'd1500;
  localparam logic [7:0]  MAX_TX_RESET  = 8'd173;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  typedef struct packed {
    logic [15:0] max_rx_length;
    logic [7:0]  max_tx_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] rx_byte;
    logic [7:0] tx_length;
    logic [7:0] payload_byte;
  } req_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] rx_expected;
    logic [15:0] rx_received;
    logic        tx_waiting;
    logic [7:0]  tx_frame_length;
    logic [7:0]  tx_left;
    logic [15:0] stall_age;
  } link_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic        payload_taken;
    logic        frame_end;
    logic [2:0]  event_res;
    logic        restart_request;
    logic [15:0] rx_frame_length;
    logic [3:0]  link_state;
  } res_t;

endpackage

>>> design/rplf_step.sv
// ----------------------------------------------------------------------------
// rplf_step: next-state and result logic for one request
// Pure combinational update of the link state from one registered request.
// ----------------------------------------------------------------------------
module rplf_step import rplf_pkg::*; (
  input  req_t  req,
  input  link_t cur,
  input  cfg_t  cfg,
  output link_t nxt,
  output res_t  res
);

  logic        go_back;   // listen, or start a held frame
  logic        do_start;
  logic [15:0] len_full;
  logic [15:0] rcv_inc;
  logic [15:0] age_inc;
  logic [7:0]  left_dec;

  assign len_full = cur.rx_expected | {8'd0, req.rx_byte};
  assign rcv_inc  = cur.rx_received + 16'd1;
  assign age_inc  = (cur.stall_age != 16'hFFFF) ? cur.stall_age + 16'd1 : cur.stall_age;
  assign left_dec = (cur.tx_left != 8'd0) ? cur.tx_left - 8'd1 : cur.tx_left;

  always_comb begin
    nxt      = cur;
    res      = '0;
    go_back  = 1'b0;
    do_start = 1'b0;

    case (req.mode)
      MODE_RX_BYTE, MODE_NOTICE: begin
        if (req.mode == MODE_NOTICE &&
            (cur.phase == PH_LEN_HI || cur.phase == PH_LEN_LO ||
             cur.phase == PH_RX_DATA)) begin
          res.event_res       = EV_RX_RESET;
          res.restart_request = 1'b1;
          nxt.rx_expected     = 16'd0;
          nxt.rx_received     = 16'd0;
          go_back             = 1'b1;
        end else if (cur.phase == PH_WAIT) begin
          res.event_res  = EV_TX_DONE;
          nxt.tx_waiting = 1'b0;
          nxt.phase      = PH_LEN_HI;
          nxt.stall_age  = 16'd0;
        end else if (req.mode == MODE_RX_BYTE) begin
          case (cur.phase)
            PH_LEN_HI: begin
              nxt.rx_expected = {req.rx_byte, 8'd0};
              nxt.phase       = PH_LEN_LO;
              nxt.stall_age   = 16'd0;
            end
            PH_LEN_LO: begin
              nxt.rx_expected = len_full;
              if (len_full == 16'd0 || len_full > cfg.max_rx_length) begin
                res.event_res = EV_RX_REJECT;
                go_back       = 1'b1;
              end else begin
                nxt.rx_received = 16'd0;
                nxt.phase       = PH_RX_DATA;
                nxt.stall_age   = 16'd0;
              end
            end
            PH_RX_DATA: begin
              res.out_byte    = req.rx_byte;
              res.kind        = KIND_RX;
              nxt.rx_received = rcv_inc;
              nxt.stall_age   = 16'd0;
              if (rcv_inc == cur.rx_expected) begin
                res.frame_end = 1'b1;
                if (cur.tx_waiting) begin
                  res.event_res = EV_TX_START;
                  do_start      = 1'b1;
                end else begin
                  nxt.phase = PH_LEN_HI;
                end
              end
            end
            default: ;  // transmit phases ignore radio bytes
          endcase
        end
      end

      MODE_QUEUE: begin
        if (req.tx_length == 8'd0 || req.tx_length > cfg.max_tx_length ||
            cur.tx_waiting) begin
          res.event_res = EV_TX_REFUSE;
        end else begin
          nxt.tx_frame_length = req.tx_length;
          if (cur.phase == PH_LEN_HI) begin
            res.event_res = EV_TX_START;
            do_start      = 1'b1;
          end else begin
            res.event_res  = EV_TX_QUEUED;
            nxt.tx_waiting = 1'b1;
          end
        end
      end

      MODE_PULL: begin
        if (cur.phase >= PH_SYNC && cur.phase <= PH_SUF2) begin
          res.kind      = KIND_TX;
          nxt.stall_age = 16'd0;
          case (cur.phase)
            PH_SYNC: begin
              if (cur.rx_received < SYNC_HI_POS) begin
                res.out_byte = PREAMBLE_BYTE;
              end else if (cur.rx_received == SYNC_HI_POS) begin
                res.out_byte = SYNC_HI_BYTE;
              end else begin
                res.out_byte = SYNC_LO_BYTE;
              end
              nxt.rx_received = rcv_inc;
              if (rcv_inc >= SYNC_LEN) begin
                nxt.phase = PH_TX_HI;
              end
            end
            PH_TX_HI: begin
              res.out_byte = 8'd0;
              nxt.phase    = PH_TX_LO;
            end
            PH_TX_LO: begin
              res.out_byte = cur.tx_frame_length;
              nxt.phase    = (cur.tx_left == 8'd0) ? PH_SUF1 : PH_TX_DATA;
            end
            PH_TX_DATA: begin
              res.out_byte      = req.payload_byte;
              res.payload_taken = 1'b1;
              nxt.tx_left       = left_dec;
              if (left_dec == 8'd0) begin
                nxt.phase = PH_SUF1;
              end
            end
            PH_SUF1: begin
              res.out_byte = PREAMBLE_BYTE;
              nxt.phase    = PH_SUF2;
            end
            default: begin
              res.out_byte  = PREAMBLE_BYTE;
              res.frame_end = 1'b1;
              nxt.phase     = PH_WAIT;
            end
          endcase
        end
      end

      MODE_TICK: begin
        if (cur.phase != PH_LEN_HI) begin
          nxt.stall_age = age_inc;
          if (age_inc > cfg.timeout_ticks) begin
            res.event_res       = EV_TIMEOUT;
            res.restart_request = 1'b1;
            if (cur.phase >= PH_SYNC) begin
              nxt.tx_waiting = 1'b0;
            end
            nxt.rx_received = 16'd0;
            go_back         = 1'b1;
          end
        end else begin
          nxt.stall_age = 16'd0;
        end
      end

      default: ;  // undefined modes do nothing
    endcase

    // go_back looks at tx_waiting as already updated above
    if (do_start || (go_back && nxt.tx_waiting)) begin
      nxt.phase       = PH_SYNC;
      nxt.rx_received = 16'd0;
      nxt.tx_left     = nxt.tx_frame_length;
      nxt.tx_waiting  = 1'b1;
      nxt.stall_age   = 16'd0;
    end else if (go_back) begin
      nxt.phase     = PH_LEN_HI;
      nxt.stall_age = 16'd0;
    end

    res.rx_frame_length = nxt.rx_expected;
    res.link_state      = nxt.phase;
  end

endmodule

>>> design/radio_packet_link_framer_core.sv
// ----------------------------------------------------------------------------
// radio_packet_link_framer_core: half-duplex length-prefixed packet framer
// Path: the accepting edge loads the request register; when that register
// advances, its result is loaded into the result register. Throughput: 1
// request per cycle; the request register advances whenever the result
// register is empty or being taken.
// Reset (rst_n low, synchronous): link listens for a length byte, counters
// cleared, configuration back to defaults, both stages empty.
// ----------------------------------------------------------------------------
module radio_packet_link_framer_core import rplf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_tx_length,
  input  logic [7:0]  in_payload_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_payload_taken,
  output logic        out_frame_end,
  output logic [2:0]  out_event_res,
  output logic        out_restart_request,
  output logic [15:0] out_rx_frame_length,
  output logic [3:0]  out_link_state
);

  cfg_t  cfg_r;
  req_t  req_r;
  logic  req_v_r;
  link_t link_r;
  link_t link_nxt;
  res_t  res_nxt;
  res_t  res_r;
  logic  res_v_r;
  logic  advance;
  logic  in_take;

  assign advance  = req_v_r && (!res_v_r || !out_stall);
  assign in_stall = req_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  rplf_step u_step (
    .req (req_r),
    .cur (link_r),
    .cfg (cfg_r),
    .nxt (link_nxt),
    .res (res_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_rx_length <= MAX_RX_RESET;
      cfg_r.max_tx_length <= MAX_TX_RESET;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_RX:  cfg_r.max_rx_length <= cfg_wdata;
        CFG_MAX_TX:  cfg_r.max_tx_length <= cfg_wdata[7:0];
        CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_take) begin
      req_v_r <= 1'b1;
    end else if (advance) begin
      req_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.mode         <= in_mode;
      req_r.rx_byte      <= in_rx_byte;
      req_r.tx_length    <= in_tx_length;
      req_r.payload_byte <= in_payload_byte;
    end
  end

  // link state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= '{phase: PH_LEN_HI, default: '0};
      res_v_r <= 1'b0;
    end else begin
      if (advance) begin
        link_r <= link_nxt;
      end
      if (advance) begin
        res_v_r <= 1'b1;
      end else if (!out_stall) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_v_r;
  assign out_byte            = res_r.out_byte;
  assign out_kind            = res_r.kind;
  assign out_payload_taken   = res_r.payload_taken;
  assign out_frame_end       = res_r.frame_end;
  assign out_event_res       = res_r.event_res;
  assign out_restart_request = res_r.restart_request;
  assign out_rx_frame_length = res_r.rx_frame_length;
  assign out_link_state      = res_r.link_state;

`ifndef SYNTHESIS
  // any transmit phase implies a frame is owned by the transmitter
  a_tx_phase_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (link_r.phase >= PH_SYNC) |-> link_r.tx_waiting)
    else $error("transmit phase without a held frame");

  // a processed request always lands in the result register
  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_v_r)
    else $error("result register not loaded after advance");

  // back-pressure only when both stages are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (req_v_r && res_v_r && out_stall))
    else $error("input stalled with a free stage");

  // payload bytes are consumed only into transmit frame bytes
  a_taken_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && res_r.payload_taken) |-> (res_r.kind == KIND_TX))
    else $error("payload taken outside a transmit byte");

  // last received byte ends the receive phase
  a_rx_end_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.kind == KIND_RX && res_nxt.frame_end) |=>
      (link_r.phase == PH_LEN_HI || link_r.phase == PH_SYNC))
    else $error("receive did not end on last byte");
`endif

endmodule

>>> tb/sv/rplf_link_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rplf_link_checker: request/result checker for the packet link framer
// Follows configuration writes, predicts one result per accepted request
// and compares every accepted result field by field, oldest first.
// ----------------------------------------------------------------------------
module rplf_link_checker import rplf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_tx_length,
  input  logic [7:0]  in_payload_byte,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  out_kind,
  input  logic        out_payload_taken,
  input  logic        out_frame_end,
  input  logic [2:0]  out_event_res,
  input  logic        out_restart_request,
  input  logic [15:0] out_rx_frame_length,
  input  logic [3:0]  out_link_state,

  output int          pending,
  output int          fail_count
);

  cfg_t  regs;
  link_t lnk;
  res_t  awaited_results[$];
  int    mismatches = 0;

  function automatic void begin_tx();
    lnk.phase       = PH_SYNC;
    lnk.rx_received = '0;
    lnk.tx_left     = lnk.tx_frame_length;
    lnk.tx_waiting  = 1'b1;
    lnk.stall_age   = '0;
  endfunction

  function automatic void listen_or_tx();
    if (lnk.tx_waiting) begin
      begin_tx();
    end else begin
      lnk.phase     = PH_LEN_HI;
      lnk.stall_age = '0;
    end
  endfunction

  // Advances the link copy by one request and returns the result it gives.
  function automatic res_t next_link_result(input req_t rq);
    res_t o;
    logic notice;
    o = '0;
    if (rq.mode == MODE_RX_BYTE || rq.mode == MODE_NOTICE) begin
      notice = (rq.mode == MODE_NOTICE);
      if (notice && lnk.phase <= PH_RX_DATA) begin
        o.event_res       = EV_RX_RESET;
        o.restart_request = 1'b1;
        lnk.rx_expected   = '0;
        lnk.rx_received   = '0;
        listen_or_tx();
      end else if (lnk.phase == PH_WAIT) begin
        o.event_res    = EV_TX_DONE;
        lnk.tx_waiting = 1'b0;
        lnk.phase      = PH_LEN_HI;
        lnk.stall_age  = '0;
      end else if (!notice) begin
        case (lnk.phase)
          PH_LEN_HI: begin
            lnk.rx_expected = {rq.rx_byte, 8'h00};
            lnk.phase       = PH_LEN_LO;
            lnk.stall_age   = '0;
          end
          PH_LEN_LO: begin
            lnk.rx_expected = lnk.rx_expected | {8'h00, rq.rx_byte};
            if (lnk.rx_expected == 16'd0 || lnk.rx_expected > regs.max_rx_length) begin
              o.event_res = EV_RX_REJECT;
              listen_or_tx();
            end else begin
              lnk.rx_received = '0;
              lnk.phase       = PH_RX_DATA;
              lnk.stall_age   = '0;
            end
          end
          PH_RX_DATA: begin
            o.out_byte      = rq.rx_byte;
            o.kind          = KIND_RX;
            lnk.rx_received = lnk.rx_received + 16'd1;
            lnk.stall_age   = '0;
            if (lnk.rx_received == lnk.rx_expected) begin
              o.frame_end = 1'b1;
              if (lnk.tx_waiting) begin
                o.event_res = EV_TX_START;
                begin_tx();
              end else begin
                lnk.phase = PH_LEN_HI;
              end
            end
          end
          default: ; // transmit phases ignore radio bytes
        endcase
      end
    end else if (rq.mode == MODE_QUEUE) begin
      if (rq.tx_length == 8'd0 || rq.tx_length > regs.max_tx_length || lnk.tx_waiting) begin
        o.event_res = EV_TX_REFUSE;
      end else begin
        lnk.tx_frame_length = rq.tx_length;
        if (lnk.phase == PH_LEN_HI) begin
          o.event_res = EV_TX_START;
          begin_tx();
        end else begin
          o.event_res    = EV_TX_QUEUED;
          lnk.tx_waiting = 1'b1;
        end
      end
    end else if (rq.mode == MODE_PULL) begin
      if (lnk.phase >= PH_SYNC && lnk.phase <= PH_SUF2) begin
        o.kind        = KIND_TX;
        lnk.stall_age = '0;
        case (lnk.phase)
          PH_SYNC: begin
            // rx_received doubles as the sync byte position here
            if (lnk.rx_received < SYNC_HI_POS)       o.out_byte = PREAMBLE_BYTE;
            else if (lnk.rx_received == SYNC_HI_POS) o.out_byte = SYNC_HI_BYTE;
            else                                     o.out_byte = SYNC_LO_BYTE;
            lnk.rx_received = lnk.rx_received + 16'd1;
            if (lnk.rx_received >= SYNC_LEN) lnk.phase = PH_TX_HI;
          end
          PH_TX_HI: begin
            o.out_byte = 8'h00;
            lnk.phase  = PH_TX_LO;
          end
          PH_TX_LO: begin
            o.out_byte = lnk.tx_frame_length;
            lnk.phase  = (lnk.tx_left == 8'd0) ? PH_SUF1 : PH_TX_DATA;
          end
          PH_TX_DATA: begin
            o.out_byte      = rq.payload_byte;
            o.payload_taken = 1'b1;
            if (lnk.tx_left > 8'd0) lnk.tx_left = lnk.tx_left - 8'd1;
            if (lnk.tx_left == 8'd0) lnk.phase = PH_SUF1;
          end
          PH_SUF1: begin
            o.out_byte = PREAMBLE_BYTE;
            lnk.phase  = PH_SUF2;
          end
          default: begin
            o.out_byte  = PREAMBLE_BYTE;
            o.frame_end = 1'b1;
            lnk.phase   = PH_WAIT;
          end
        endcase
      end
    end else if (rq.mode == MODE_TICK) begin
      if (lnk.phase != PH_LEN_HI) begin
        if (lnk.stall_age != 16'hFFFF) lnk.stall_age = lnk.stall_age + 16'd1;
        if (lnk.stall_age > regs.timeout_ticks) begin
          o.event_res       = EV_TIMEOUT;
          o.restart_request = 1'b1;
          if (lnk.phase >= PH_SYNC) lnk.tx_waiting = 1'b0;
          lnk.rx_received = '0;
          listen_or_tx();
        end
      end else begin
        lnk.stall_age = '0;
      end
    end
    o.rx_frame_length = lnk.rx_expected;
    o.link_state      = lnk.phase;
    return o;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    req_t rq;
    res_t want;
    if (!rst_n) begin
      regs.max_rx_length = MAX_RX_RESET;
      regs.max_tx_length = MAX_TX_RESET;
      regs.timeout_ticks = TIMEOUT_RESET;
      lnk = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_RX:  regs.max_rx_length = cfg_wdata;
          CFG_MAX_TX:  regs.max_tx_length = cfg_wdata[7:0];
          CFG_TIMEOUT: regs.timeout_ticks = cfg_wdata;
          default: ;
        endcase
      end
      // results first, so a stray result never meets this edge's request
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("out_byte", int'(want.out_byte), int'(out_byte));
          check_field("out_kind", int'(want.kind), int'(out_kind));
          check_field("out_payload_taken", int'(want.payload_taken),
                      int'(out_payload_taken));
          check_field("out_frame_end", int'(want.frame_end), int'(out_frame_end));
          check_field("out_event_res", int'(want.event_res), int'(out_event_res));
          check_field("out_restart_request", int'(want.restart_request),
                      int'(out_restart_request));
          check_field("out_rx_frame_length", int'(want.rx_frame_length),
                      int'(out_rx_frame_length));
          check_field("out_link_state", int'(want.link_state), int'(out_link_state));
        end
      end
      if (in_valid && !in_stall) begin
        rq.mode         = in_mode;
        rq.rx_byte      = in_rx_byte;
        rq.tx_length    = in_tx_length;
        rq.payload_byte = in_payload_byte;
        awaited_results.push_back(next_link_result(rq));
      end
    end
    pending    <= awaited_results.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/sv/tb_radio_packet_link_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radio_packet_link_framer_core: testbench top for the packet link framer
// Drives directed and randomized receive/transmit request sequences with
// random gaps and result back-pressure across several register settings;
// the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_radio_packet_link_framer_core import rplf_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_tx_length;
  logic [7:0]  in_payload_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_payload_taken;
  logic        out_frame_end;
  logic [2:0]  out_event_res;
  logic        out_restart_request;
  logic [15:0] out_rx_frame_length;
  logic [3:0]  out_link_state;
  int          pending;
  int          fail_count;

  int sent        = 0;
  int steady_left = 0;
  int cur_max_rx  = int'(MAX_RX_RESET);
  int cur_max_tx  = int'(MAX_TX_RESET);
  int cur_timeout = int'(TIMEOUT_RESET);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  radio_packet_link_framer_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_rx_byte          (in_rx_byte),
    .in_tx_length        (in_tx_length),
    .in_payload_byte     (in_payload_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_kind            (out_kind),
    .out_payload_taken   (out_payload_taken),
    .out_frame_end       (out_frame_end),
    .out_event_res       (out_event_res),
    .out_restart_request (out_restart_request),
    .out_rx_frame_length (out_rx_frame_length),
    .out_link_state      (out_link_state)
  );

  rplf_link_checker i_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_rx_byte          (in_rx_byte),
    .in_tx_length        (in_tx_length),
    .in_payload_byte     (in_payload_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_kind            (out_kind),
    .out_payload_taken   (out_payload_taken),
    .out_frame_end       (out_frame_end),
    .out_event_res       (out_event_res),
    .out_restart_request (out_restart_request),
    .out_rx_frame_length (out_rx_frame_length),
    .out_link_state      (out_link_state),
    .pending             (pending),
    .fail_count          (fail_count)
  );

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int min_of(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // One request; valid stays high into the next request unless a gap is taken.
  task automatic send(input logic [2:0] m, input logic [7:0] rb, input logic [7:0] tl,
                      input logic [7:0] pb);
    int gap;
    int r;
    gap = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4)       steady_left = $urandom_range(15, 40);
      else if (r < 60) gap = 0;
      else if (r < 93) gap = $urandom_range(1, 2);
      else             gap = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_rx_byte      <= rb;
    in_tx_length    <= tl;
    in_payload_byte <= pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic radio_byte(input logic [7:0] b);
    send(MODE_RX_BYTE, b, rnd8(), rnd8());
  endtask

  task automatic radio_notice();
    send(MODE_NOTICE, rnd8(), rnd8(), rnd8());
  endtask

  task automatic queue_frame(input logic [7:0] len);
    send(MODE_QUEUE, rnd8(), len, rnd8());
  endtask

  task automatic pull_byte();
    send(MODE_PULL, rnd8(), rnd8(), rnd8());
  endtask

  task automatic tick();
    send(MODE_TICK, rnd8(), rnd8(), rnd8());
  endtask

  task automatic finish_tx(input int len);
    for (int i = 0; i < 9 + len; i++) begin
      if ($urandom_range(0, 9) == 0) tick();
      pull_byte();
    end
    if ($urandom_range(0, 9) == 0) pull_byte();  // pull while waiting: no output
    if ($urandom_range(0, 1) == 0) radio_notice();
    else radio_byte(rnd8());
  endtask

  task automatic rx_frame();
    int len;
    int n;
    bit bad;
    bad = ($urandom_range(0, 9) == 0);
    if (bad) begin
      case ($urandom_range(0, 2))
        0:       len = 0;
        1:       len = cur_max_rx + 1;
        default: len = $urandom_range(0, 65535);
      endcase
    end else if ($urandom_range(0, 19) == 0 && cur_max_rx <= 64) begin
      len = cur_max_rx;
    end else begin
      len = $urandom_range(1, min_of(cur_max_rx, 8));
    end
    radio_byte(len[15:8]);
    radio_byte(len[7:0]);
    n = bad ? 0 : len;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);  // broken-off frame
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) tick();
      radio_byte(rnd8());
    end
  endtask

  task automatic tx_frame();
    int len;
    if ($urandom_range(0, 29) == 0) len = cur_max_tx;
    else len = $urandom_range(1, min_of(cur_max_tx, 6));
    queue_frame(8'(len));
    finish_tx(len);
  endtask

  // Transmit queued mid-receive: held until the receive ends or is rejected.
  task automatic rx_with_held_tx();
    int len;
    int tl;
    len = $urandom_range(1, min_of(cur_max_rx, 5));
    tl  = $urandom_range(1, min_of(cur_max_tx, 4));
    radio_byte(8'h00);
    queue_frame(8'(tl));
    if ($urandom_range(0, 3) == 0) begin
      radio_byte(8'h00);
    end else begin
      radio_byte(8'(len));
      for (int i = 0; i < len; i++) radio_byte(rnd8());
    end
    finish_tx(tl);
  endtask

  task automatic stall_link();
    int n;
    if ($urandom_range(0, 1) == 0) radio_byte(rnd8());
    else queue_frame(8'($urandom_range(1, min_of(cur_max_tx, 4))));
    n = (cur_timeout < 10) ? cur_timeout + $urandom_range(0, 2) : $urandom_range(1, 6);
    repeat (n) tick();
  endtask

  task automatic random_phase(input int count);
    int stop;
    int r;
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 30)      rx_frame();
      else if (r < 55) tx_frame();
      else if (r < 67) rx_with_held_tx();
      else if (r < 80) stall_link();
      else begin
        repeat ($urandom_range(1, 4))
          send(3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8());
      end
    end
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input int mrx, input int mtx, input int tmo);
    cur_max_rx  = mrx;
    cur_max_tx  = mtx;
    cur_timeout = tmo;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_RX;
    cfg_wdata <= 16'(mrx);
    @(posedge clk);
    cfg_index <= CFG_MAX_TX;
    cfg_wdata <= {rnd8(), 8'(mtx)};  // upper byte is don't-care for this register
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= 16'(tmo);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold so the core backs up.
  initial begin : result_sink
    int run;
    int taken;
    int r;
    bit held;
    run   = 0;
    taken = 0;
    held  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (!held && taken >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        run = 150;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          run = $urandom_range(0, 20);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          run = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(5, 25);
        end
      end
    end
  end

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MAX_RX;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_mode         = MODE_TICK;
    in_rx_byte      = '0;
    in_tx_length    = '0;
    in_payload_byte = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: refusals, rejects, held transmit, reset notices, full frame
    queue_frame(8'd0);
    queue_frame(8'hFF);
    radio_byte(8'h00);
    radio_byte(8'h00);
    radio_byte(8'hFF);
    radio_byte(8'hFF);
    radio_byte(8'h00);
    radio_byte(8'h02);
    queue_frame(8'd1);        // held behind the receive
    queue_frame(8'd2);        // refused, one already held
    radio_byte(8'hFF);
    radio_notice();           // receive restarted, held frame starts
    radio_byte(8'h55);        // ignored while transmitting
    radio_notice();           // ignored while transmitting
    repeat (10) pull_byte();
    pull_byte();              // waiting for completion: nothing out
    radio_notice();           // counts as completion
    tick();
    send(3'd7, 8'hFF, 8'hFF, 8'hFF);

    random_phase(150);
    settle();
    load_regs(1, 1, 1);
    random_phase(150);
    settle();
    load_regs(65535, 255, 65535);
    random_phase(150);
    settle();
    load_regs($urandom_range(2, 40), $urandom_range(2, 12), $urandom_range(2, 8));
    random_phase(170);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("tb_radio_packet_link_framer_core: done, clean");
    end else begin
      $display("tb_radio_packet_link_framer_core: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_radio_packet_link_framer_core: done, errors");
    $finish;
  end

endmodule
